>>> rtl/core/ptht_pkg.sv
// Shared constants, codes and types of the allocation-record hash table.
`timescale 1ns / 1ps
`default_nettype none

package ptht_pkg;

  // Default table depth
  localparam int unsigned TABLE_SLOTS_DEF = 8192;

  // Field widths
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 14;

  // Hash: xor-shift, multiply by golden-ratio constant, xor-shift
  localparam logic [31:0] HASH_MUL   = 32'h9e37_79b9;
  localparam int unsigned HASH_SHIFT = 16;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 2'd3;

  // One table slot as held in memory
  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
    logic              aligned;
  } slot_entry_t;

endpackage

`default_nettype wire

>>> rtl/core/ptht_ifs.sv
// Request and response channel interfaces of the allocation-record hash table.
`timescale 1ns / 1ps
`default_nettype none

interface ptht_req_if;
  import ptht_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [KEY_W-1:0]  key_addr;
  logic [SIZE_W-1:0] block_size;
  logic              aligned_in;

  modport source (output valid, output req_type, output key_addr, output block_size,
                  output aligned_in, input ready);
  modport sink   (input valid, input req_type, input key_addr, input block_size,
                  input aligned_in, output ready);
endinterface

interface ptht_rsp_if;
  import ptht_pkg::*;

  logic                valid;
  logic                ready;
  logic                hit;
  logic [SIZE_W-1:0]   size_out;
  logic                aligned_out;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  live_count;

  modport source (output valid, output hit, output size_out, output aligned_out,
                  output status, output live_count, input ready);
  modport sink   (input valid, input hit, input size_out, input aligned_out,
                  input status, input live_count, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ptht_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ptht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/pointer_tracking_hash_table_unit.sv
// Allocation-record table: linear-probing hash table over one slot memory.
//
//   channel | dir | beat contents                                  | accepted when
//   --------+-----+------------------------------------------------+--------------
//   req     | in  | req_type, key_addr, block_size, aligned_in     | valid & ready
//   rsp     | out | hit, size_out, aligned_out, status, live_count | valid & ready
//
// Flow: one request at a time. A request is hashed (S_MUL_LO, S_MUL_HI, S_HASH), then
// probed one slot per cycle through the memory read port, up to TABLE_SLOTS slots;
// depths that are not a power of two add a slot-index reduction (S_MOD) before the
// probe. A null key or unused request code skips straight to the result (S_OUT).
// Reset: a clearing pass writes every slot empty, with req.ready low.
// Stalls: the result sits in an output register; the next request is taken while
// it waits, and a finished request holds until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module pointer_tracking_hash_table_unit #(
  parameter int unsigned TABLE_SLOTS = ptht_pkg::TABLE_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ptht_req_if.sink   req,
  ptht_rsp_if.source rsp
);
  import ptht_pkg::*;

  localparam int unsigned IDX_W     = $clog2(TABLE_SLOTS);
  localparam int unsigned CNT_W     = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned REM_W     = IDX_W + 1;
  localparam bit          IS_POW2   = (TABLE_SLOTS == (1 << IDX_W));
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned MOD_STEPS = KEY_W / DIGIT_W;
  localparam int unsigned MSTEP_W   = $clog2(MOD_STEPS);
  localparam int unsigned ENTRY_W   = $bits(slot_entry_t);

  localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [REM_W-1:0]   SLOTS_REM = REM_W'(TABLE_SLOTS);
  localparam logic [CNT_W-1:0]   SLOTS_CNT = CNT_W'(TABLE_SLOTS);
  localparam logic [MSTEP_W-1:0] MOD_LAST  = MSTEP_W'(MOD_STEPS - 1);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_MUL_LO = 8'b0000_0100,
    S_MUL_HI = 8'b0000_1000,
    S_HASH   = 8'b0001_0000,
    S_MOD    = 8'b0010_0000,
    S_PROBE  = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t state;

  // Latched request
  logic [REQ_W-1:0]  req_type_r;
  logic [KEY_W-1:0]  key_r;
  logic [SIZE_W-1:0] size_r;
  logic              aligned_r;

  // Hash datapath
  logic [KEY_W-1:0]  x1;
  logic [31:0]       mul_a;
  logic [63:0]       mul_p;
  logic [63:0]       prod_lo;
  logic [31:0]       prod_hi;
  logic [KEY_W-1:0]  x2;
  logic [KEY_W-1:0]  x3;

  // Slot-index reduction for depths that are not a power of two
  logic [KEY_W-1:0]   rem_sh;
  logic [REM_W-1:0]   rem;
  logic [REM_W-1:0]   rem_step;
  logic [MSTEP_W-1:0] mod_cnt;

  // Probe pipeline
  logic [IDX_W-1:0] clr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [CNT_W-1:0] rd_cnt;
  logic             chk_valid;
  logic [IDX_W-1:0] chk_idx;
  slot_entry_t      rd_entry;
  logic             is_insert;
  logic             probe_stop;
  logic             probe_done;

  // Memory ports
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  slot_entry_t        ram_wentry;
  logic [ENTRY_W-1:0] ram_rdata;

  // Result staging and output register
  logic                res_hit;
  logic [SIZE_W-1:0]   res_size;
  logic                res_aligned;
  logic [STATUS_W-1:0] res_status;
  logic [CNT_W-1:0]    live;
  logic [CNT_W+COUNT_W-1:0] live_ext;

  logic                out_valid;
  logic                out_hit;
  logic [SIZE_W-1:0]   size_hold;
  logic                out_aligned;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_live;

  // Slot memory
  ptht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // Hash: one 32x32 multiply per cycle, low half of the folded key first, then the high half
  assign x1    = key_r ^ (key_r >> HASH_SHIFT);
  assign mul_a = (state == S_MUL_HI) ? x1[63:32] : x1[31:0];
  assign mul_p = {32'b0, mul_a} * {32'b0, HASH_MUL};
  assign x2    = prod_lo + {prod_hi, 32'b0};
  assign x3    = x2 ^ (x2 >> HASH_SHIFT);

  // One hex digit of restoring reduction per cycle
  always_comb begin
    rem_step = rem;
    for (int j = 0; j < DIGIT_W; j++) begin
      rem_step = {rem_step[REM_W-2:0], rem_sh[KEY_W-1-j]};
      if (rem_step >= SLOTS_REM) begin
        rem_step = rem_step - SLOTS_REM;
      end
    end
  end

  // Probe evaluation on the slot read last cycle
  assign rd_entry   = slot_entry_t'(ram_rdata);
  assign is_insert  = (req_type_r == REQ_INSERT);
  assign probe_stop = chk_valid && (is_insert ? !rd_entry.valid
                                              : (rd_entry.valid && rd_entry.key == key_r));
  assign probe_done = !chk_valid && (rd_cnt == SLOTS_CNT);

  // Memory write: clearing pass, insert into a free slot, or free a removed slot
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = chk_idx;
    ram_wentry = '0;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx;
    end else if (state == S_PROBE && probe_stop && req_type_r != REQ_LOOKUP) begin
      ram_we = 1'b1;
      if (is_insert) begin
        ram_wentry.valid   = 1'b1;
        ram_wentry.key     = key_r;
        ram_wentry.size    = size_r;
        ram_wentry.aligned = aligned_r;
      end
    end
  end

  assign live_ext = {{COUNT_W{1'b0}}, live};

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      live      <= '0;
      out_valid <= 1'b0;
      chk_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IDX_W'(1);
          if (clr_idx == LAST_IDX) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (req.valid) begin
            req_type_r  <= req.req_type;
            key_r       <= req.key_addr;
            size_r      <= req.block_size;
            aligned_r   <= req.aligned_in;
            res_hit     <= 1'b0;
            res_size    <= '0;
            res_aligned <= 1'b0;
            res_status  <= ST_IGNORED;
            if (req.key_addr != '0 && (req.req_type == REQ_INSERT ||
                                       req.req_type == REQ_LOOKUP ||
                                       req.req_type == REQ_REMOVE)) begin
              state <= S_MUL_LO;
            end else begin
              state <= S_OUT;
            end
          end
        end

        S_MUL_LO: begin
          prod_lo <= mul_p;
          state   <= S_MUL_HI;
        end

        S_MUL_HI: begin
          prod_hi <= mul_p[31:0];
          state   <= S_HASH;
        end

        S_HASH: begin
          rd_cnt    <= '0;
          chk_valid <= 1'b0;
          if (IS_POW2) begin
            rd_idx <= x3[IDX_W-1:0];
            state  <= S_PROBE;
          end else begin
            rem_sh  <= x3;
            rem     <= '0;
            mod_cnt <= '0;
            state   <= S_MOD;
          end
        end

        S_MOD: begin
          rem     <= rem_step;
          rem_sh  <= rem_sh << DIGIT_W;
          mod_cnt <= mod_cnt + MSTEP_W'(1);
          if (mod_cnt == MOD_LAST) begin
            rd_idx <= rem_step[IDX_W-1:0];
            state  <= S_PROBE;
          end
        end

        S_PROBE: begin
          // issue the next slot read while checking the previous one
          if (rd_cnt != SLOTS_CNT) begin
            rd_idx    <= (rd_idx == LAST_IDX) ? '0 : rd_idx + IDX_W'(1);
            rd_cnt    <= rd_cnt + CNT_W'(1);
            chk_idx   <= rd_idx;
            chk_valid <= 1'b1;
          end else begin
            chk_valid <= 1'b0;
          end

          if (probe_stop) begin
            chk_valid  <= 1'b0;
            res_status <= ST_OK;
            state      <= S_OUT;
            if (is_insert) begin
              live <= live + CNT_W'(1);
            end else begin
              res_hit     <= 1'b1;
              res_size    <= rd_entry.size;
              res_aligned <= rd_entry.aligned;
              if (req_type_r == REQ_REMOVE) begin
                live <= live - CNT_W'(1);
              end
            end
          end else if (probe_done) begin
            res_status <= is_insert ? ST_FULL : ST_NOT_FOUND;
            state      <= S_OUT;
          end
        end

        S_OUT: begin
          if (!out_valid || rsp.ready) begin
            out_valid   <= 1'b1;
            out_hit     <= res_hit;
            size_hold   <= res_size;
            out_aligned <= res_aligned;
            out_status  <= res_status;
            out_live    <= live_ext[COUNT_W-1:0];
            state       <= S_IDLE;
          end
        end

        default: state <= S_CLEAR;
      endcase
    end
  end

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.hit         = out_hit;
  assign rsp.size_out    = size_hold;
  assign rsp.aligned_out = out_aligned;
  assign rsp.status      = out_status;
  assign rsp.live_count  = out_live;

endmodule

`default_nettype wire

>>> rtl/core/ptht_checker.sv
// Port-level checks on the allocation-record hash table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ptht_checker #(
  parameter int unsigned TABLE_SLOTS = ptht_pkg::TABLE_SLOTS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic                          rsp_hit,
  input logic [ptht_pkg::SIZE_W-1:0]   rsp_size_out,
  input logic                          rsp_aligned_out,
  input logic [ptht_pkg::STATUS_W-1:0] rsp_status,
  input logic [ptht_pkg::COUNT_W-1:0]  rsp_live_count
);
  import ptht_pkg::*;

  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(TABLE_SLOTS % (1 << COUNT_W));

  // The clearing pass keeps requests out right after reset
  a_clear_blocks_req: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !req_ready)
    else $error("request taken during clearing pass");

  // A full table means every slot holds a record
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_FULL |-> rsp_live_count == FULL_COUNT)
    else $error("table full reported with free slots");

  // No result appears in the cycle right after a request beat
  a_no_instant_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !$rose(rsp_valid))
    else $error("result raised one cycle after request");

  // A stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid &&
      $stable({rsp_hit, rsp_size_out, rsp_aligned_out, rsp_status, rsp_live_count}))
    else $error("stalled result beat changed");

endmodule

bind pointer_tracking_hash_table_unit ptht_checker #(
  .TABLE_SLOTS (TABLE_SLOTS)
) u_ptht_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_hit         (rsp.hit),
  .rsp_size_out    (rsp.size_out),
  .rsp_aligned_out (rsp.aligned_out),
  .rsp_status      (rsp.status),
  .rsp_live_count  (rsp.live_count)
);

`default_nettype wire

>>> bench/tb_pointer_tracking_hash_table_unit.sv
// Self-checking bench for the allocation-record hash table: predicted responses per request beat.
`timescale 1ns / 1ps

module tb_pointer_tracking_hash_table_unit;
  import ptht_pkg::*;

  localparam int unsigned SLOTS       = TABLE_SLOTS_DEF;
  localparam int unsigned RAND_TARGET = 870;
  // worst beat is a full-table scan plus the longest gap and stall, taken four times
  localparam int unsigned STUCK_LIMIT = 4 * (SLOTS + 64);
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] HASH_MUL64 = {32'd0, HASH_MUL};

  typedef struct packed {
    logic [REQ_W-1:0]  op;
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
    logic              aligned;
  } table_req_t;

  typedef struct packed {
    logic                hit;
    logic [SIZE_W-1:0]   size;
    logic                aligned;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  live;
  } table_rsp_t;

  // Mirror of the record table; predicts each response and checks the ones that arrive
  class alloc_table_sb;
    bit [KEY_W-1:0]  slot_key     [SLOTS];
    bit [SIZE_W-1:0] slot_size    [SLOTS];
    bit              slot_aligned [SLOTS];
    bit              slot_used    [SLOTS];
    int unsigned     records;
    table_rsp_t      due_rsp [$];
    int unsigned     fails;

    function int unsigned home_slot(bit [KEY_W-1:0] addr);
      bit [KEY_W-1:0] x;
      x = addr;
      x ^= x >> HASH_SHIFT;
      x = x * HASH_MUL64;
      x ^= x >> HASH_SHIFT;
      return int'(x % SLOTS);
    endfunction

    // first live slot holding addr in probe order; free slots do not end the scan
    function int find_record(bit [KEY_W-1:0] addr);
      int unsigned idx;
      idx = home_slot(addr);
      repeat (SLOTS) begin
        if (slot_used[idx] && slot_key[idx] == addr) return int'(idx);
        idx = (idx + 1) % SLOTS;
      end
      return -1;
    endfunction

    // apply one accepted request to the mirror and queue the response it must give
    function void note_request(table_req_t r);
      table_rsp_t e;
      int         idx;
      e = '0;
      e.status = ST_IGNORED;
      if (r.key != '0 && r.op == REQ_INSERT) begin
        e.status = ST_FULL;
        idx = int'(home_slot(r.key));
        repeat (SLOTS) begin
          if (!slot_used[idx]) begin
            slot_key[idx]     = r.key;
            slot_size[idx]    = r.size;
            slot_aligned[idx] = r.aligned;
            slot_used[idx]    = 1'b1;
            records++;
            e.status = ST_OK;
            break;
          end
          idx = (idx + 1) % SLOTS;
        end
      end else if (r.key != '0 && (r.op == REQ_LOOKUP || r.op == REQ_REMOVE)) begin
        idx = find_record(r.key);
        if (idx < 0) begin
          e.status = ST_NOT_FOUND;
        end else begin
          e.hit     = 1'b1;
          e.size    = slot_size[idx];
          e.aligned = slot_aligned[idx];
          e.status  = ST_OK;
          if (r.op == REQ_REMOVE) begin
            slot_used[idx] = 1'b0;
            if (records > 0) records--;
          end
        end
      end
      e.live = COUNT_W'(records);
      due_rsp.push_back(e);
    endfunction

    function void fail_note(string what, table_rsp_t e, table_rsp_t g);
      fails++;
      if (fails <= 10)
        $display("%t %s: exp hit=%0b size=%h al=%0b st=%0d live=%0d",
                 $time, what, e.hit, e.size, e.aligned, e.status, e.live,
                 " / got hit=%0b size=%h al=%0b st=%0d live=%0d",
                 g.hit, g.size, g.aligned, g.status, g.live);
    endfunction

    function void check_response(table_rsp_t got);
      table_rsp_t e;
      if (due_rsp.size() == 0) begin
        fail_note("response beat with no request pending", '0, got);
        return;
      end
      e = due_rsp.pop_front();
      if (got.hit !== e.hit || got.size !== e.size || got.aligned !== e.aligned ||
          got.status !== e.status || got.live !== e.live)
        fail_note("response mismatch", e, got);
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   send_idle = 1'b1;
  bit   recv_idle = 1'b1;
  int unsigned stuck_cycles;

  ptht_req_if req_ch ();
  ptht_rsp_if rsp_ch ();

  alloc_table_sb sb = new();

  pointer_tracking_hash_table_unit #(.TABLE_SLOTS(SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: too long without any beat on either channel ends the run
  always @(posedge clk) begin
    if (rst === 1'b1 || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic table_req_t req_item(logic [REQ_W-1:0] op, logic [KEY_W-1:0] addr,
                                          logic [SIZE_W-1:0] bytes, logic al);
    table_req_t r;
    r.op      = op;
    r.key     = addr;
    r.size    = bytes;
    r.aligned = al;
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] undo_xorshift(logic [KEY_W-1:0] v);
    return v ^ (v >> HASH_SHIFT) ^ (v >> (2 * HASH_SHIFT)) ^ (v >> (3 * HASH_SHIFT));
  endfunction

  // Random nonzero key whose hash lands on slot s (the hash is inverted step by step)
  function automatic logic [KEY_W-1:0] key_for_slot(int unsigned s);
    logic [KEY_W-1:0] inv;
    logic [KEY_W-1:0] v;
    inv = HASH_MUL64;
    repeat (6) inv = inv * (64'd2 - HASH_MUL64 * inv);
    do begin
      v = {$urandom, $urandom};
      v = v - (v % SLOTS) + s;
      v = undo_xorshift(v);
      v = v * inv;
      v = undo_xorshift(v);
    end while (v == '0);
    return v;
  endfunction

  // A key currently stored; a fresh random key when the table is empty
  function automatic bit pick_live(output logic [KEY_W-1:0] k);
    int unsigned idx;
    idx = $urandom_range(0, SLOTS - 1);
    repeat (SLOTS) begin
      if (sb.slot_used[idx]) begin
        k = sb.slot_key[idx];
        return 1'b1;
      end
      idx = (idx + 1) % SLOTS;
    end
    k = {$urandom, $urandom};
    return 1'b0;
  endfunction

  // Drive one request beat after a random gap; valid stays up when the gap is zero
  task automatic send_req(table_req_t r);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= r.op;
    req_ch.key_addr   <= r.key;
    req_ch.block_size <= r.size;
    req_ch.aligned_in <= r.aligned;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_request(r);
  endtask

  // Hold off new requests until every predicted response has arrived
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.due_rsp.size() != 0);
  endtask

  // Response side: random stall before each beat, then check it
  initial begin : rsp_sink
    table_rsp_t  got;
    int unsigned stall;
    rsp_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = recv_idle ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      got.hit     = rsp_ch.hit;
      got.size    = rsp_ch.size_out;
      got.aligned = rsp_ch.aligned_out;
      got.status  = rsp_ch.status;
      got.live    = rsp_ch.live_count;
      sb.check_response(got);
    end
  end

  initial begin : stimulus
    logic [KEY_W-1:0]  key_a, key_b, key_c, key;
    logic [REQ_W-1:0]  op;
    logic [SIZE_W-1:0] bytes;
    logic              al;
    int unsigned       counted, n, roll, sel;

    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= REQ_INSERT;
    req_ch.key_addr     <= '0;
    req_ch.block_size   <= '0;
    req_ch.aligned_in   <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: null keys, unused code, misses on an empty table, wrap-around
    // collisions, duplicates and a lookup that must step over a freed slot
    key_a = key_for_slot(SLOTS - 1);
    do key_b = key_for_slot(SLOTS - 1); while (key_b == key_a);
    key_c = key_for_slot(0);
    send_req(req_item(REQ_LOOKUP, '0, 32'h1234_5678, 1'b1));
    send_req(req_item(REQ_INSERT, '0, '1, 1'b1));
    send_req(req_item(REQ_REMOVE, '0, '0, 1'b0));
    send_req(req_item(REQ_UNUSED, '1, '1, 1'b1));
    send_req(req_item(REQ_UNUSED, '0, '0, 1'b0));
    send_req(req_item(REQ_LOOKUP, '1, '0, 1'b0));
    send_req(req_item(REQ_REMOVE, key_a, '0, 1'b0));
    send_req(req_item(REQ_INSERT, '1, '1, 1'b1));
    send_req(req_item(REQ_LOOKUP, '1, '0, 1'b0));
    send_req(req_item(REQ_INSERT, key_a, '0, 1'b0));
    send_req(req_item(REQ_INSERT, key_b, 32'h5a5a_5a5a, 1'b1));
    send_req(req_item(REQ_INSERT, key_c, 32'ha5a5_a5a5, 1'b0));
    send_req(req_item(REQ_INSERT, key_a, 32'h0000_0001, 1'b1));
    send_req(req_item(REQ_LOOKUP, key_a, '0, 1'b0));
    send_req(req_item(REQ_REMOVE, key_a, '0, 1'b0));
    send_req(req_item(REQ_LOOKUP, key_b, '0, 1'b0));
    send_req(req_item(REQ_LOOKUP, key_a, '0, 1'b0));
    send_req(req_item(REQ_REMOVE, key_a, '0, 1'b0));
    send_req(req_item(REQ_LOOKUP, key_a, '0, 1'b0));
    send_req(req_item(REQ_REMOVE, key_c, '0, 1'b0));
    send_req(req_item(REQ_REMOVE, '1, '0, 1'b0));
    send_req(req_item(REQ_REMOVE, key_b, '0, 1'b0));
    wait_drained();

    // Random traffic: mostly hits on stored keys, clustered inserts near the
    // wrap point, a few costly misses, plus null keys and the unused code
    counted = 0;
    n = 0;
    while (counted < RAND_TARGET) begin
      if (n % 60 == 0) begin
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
      end
      if (n % 250 == 249) wait_drained();
      n++;
      roll = $urandom_range(0, 99);
      if (sb.records > 200 && roll < 40) roll = 65;
      sel   = $urandom_range(0, 9);
      bytes = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? '1 : '0) : $urandom;
      al    = $urandom_range(0, 1);
      op    = REQ_INSERT;
      key   = {$urandom, $urandom};
      if (roll < 40) begin
        // insert: fresh key, colliding key near the last slot, or a duplicate
        if (sel < 3) key = key_for_slot((SLOTS - 8 + $urandom_range(0, 15)) % SLOTS);
        else if (sel == 3) void'(pick_live(key));
      end else if (roll < 80) begin
        op = (roll < 62) ? REQ_LOOKUP : REQ_REMOVE;
        if (!pick_live(key)) op = REQ_INSERT;
      end else if (roll < 84) begin
        // miss: scans the whole table
        op = (roll < 82) ? REQ_LOOKUP : REQ_REMOVE;
      end else if (roll < 92) begin
        key = '0;
        op  = REQ_W'($urandom_range(0, 3));
      end else begin
        op = REQ_UNUSED;
      end
      send_req(req_item(op, key, bytes, al));
      counted++;
    end
    wait_drained();

    // Tail: fresh insert, miss, then free one slot, refill, and hit stored keys
    send_idle = 1'b1;
    recv_idle = 1'b1;
    send_req(req_item(REQ_INSERT, {$urandom, $urandom}, $urandom, 1'b1));
    send_req(req_item(REQ_LOOKUP, {$urandom, $urandom}, '0, 1'b0));
    void'(pick_live(key));
    send_req(req_item(REQ_REMOVE, key, '0, 1'b0));
    send_req(req_item(REQ_INSERT, {$urandom, $urandom}, $urandom, 1'b0));
    send_req(req_item(REQ_INSERT, {$urandom, $urandom}, $urandom, 1'b1));
    repeat (4) begin
      void'(pick_live(key));
      send_req(req_item(REQ_LOOKUP, key, '0, 1'b0));
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
